// File: rtl/core/stfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table floor search: shared package
// Types, widths and default sizes used by the front end, the search engine
// and the top level.
// ----------------------------------------------------------------------------
package stfs_pkg;

  // Default table geometry.
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int TIME_BITS_DEF   = 32;

  // Fixed port widths.
  localparam int IN_TIME_W = 32;
  localparam int INDEX_W   = 10;
  localparam int COUNT_W   = 11;

  // Depth of the queues between the parts (power of two).
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // One classified command from the front end.
  typedef struct packed {
    opcode_t              op;
    logic [INDEX_W-1:0]   index;
    logic [IN_TIME_W-1:0] time_value;
  } cmd_t;

  // One search answer.
  typedef struct packed {
    logic               found;
    logic               exact_hit;
    logic [INDEX_W-1:0] result_index;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_REPLY
  } back_state_t;

endpackage

// File: rtl/core/sorted_table_floor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table floor search: top level
// Table of ascending timestamps with a binary floor search on query.
// ----------------------------------------------------------------------------
// Write beats load one table entry; query beats return the index of the
// first probed entry equal to the target, or else of the greatest entry
// below it, or found = 0. Both sides behave as queues: push while full is
// low, pop while empty is low. A write is done in the idle state. A query
// passes through an issue in the idle state, a probe per halving of the
// window and a reply that waits while the result queue is full; the
// single-port table memory delivers one probe per cycle. Entries must be
// written before a query searches over them. Change entry_count only while
// no query is pending.
// ----------------------------------------------------------------------------
module sorted_table_floor_search #(
  parameter int TABLE_DEPTH = stfs_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS   = stfs_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_opcode,
  input  logic [stfs_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [stfs_pkg::IN_TIME_W-1:0] in_time_value,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_found,
  output logic                           out_exact_hit,
  output logic [stfs_pkg::INDEX_W-1:0]   out_result_index,
  input  logic                           cfg_wr_en,
  input  logic [stfs_pkg::COUNT_W-1:0]   cfg_entry_count
);

  import stfs_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  result_t res;

  stfs_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_time_value  (in_time_value),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  stfs_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_entry_count (cfg_entry_count),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_res         (res)
  );

  // Result fields.
  assign out_found        = res.found;
  assign out_exact_hit    = res.exact_hit;
  assign out_result_index = res.result_index;

endmodule

// File: rtl/core/stfs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table floor search: small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module stfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/stfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table floor search: front end
// Accepts input beats, drops writes outside the table and queues the rest
// as commands for the search engine.
// ----------------------------------------------------------------------------
module stfs_front #(
  parameter int TABLE_DEPTH = stfs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_opcode,
  input  logic [stfs_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [stfs_pkg::IN_TIME_W-1:0] in_time_value,
  output logic                           cmd_valid,
  output stfs_pkg::cmd_t                 cmd,
  input  logic                           cmd_pop
);

  import stfs_pkg::*;

  cmd_t cmd_in;
  logic in_range;
  logic keep;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_rd_data;

  // Classify the incoming beat; a write beyond the table has no effect.
  always_comb begin
    cmd_in.op         = opcode_t'(in_opcode);
    cmd_in.index      = in_entry_index;
    cmd_in.time_value = in_time_value;
    in_range          = (32'(in_entry_index) < 32'(TABLE_DEPTH));
    keep              = (cmd_in.op == OP_QUERY) || in_range;
  end

  stfs_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push && keep),
    .wr_data (cmd_in),
    .full    (in_full),
    .pop     (cmd_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_rd_data);

endmodule

// File: rtl/core/stfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table floor search: search engine
// Owns the timestamp table and the entry count, writes entries, runs the
// binary search one probe per cycle and queues the answers.
// ----------------------------------------------------------------------------
module stfs_back #(
  parameter int TABLE_DEPTH = stfs_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS   = stfs_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [stfs_pkg::COUNT_W-1:0] cfg_entry_count,
  input  logic                         cmd_valid,
  input  stfs_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output stfs_pkg::result_t            out_res
);

  import stfs_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = AW + 1;

  // Table storage.
  logic [TIME_BITS-1:0] mem [TABLE_DEPTH];

  back_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic [CNTW-1:0]      lo_r, lo_nxt;
  logic [CNTW-1:0]      hx_r, hx_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic [AW-1:0]        best_r, best_nxt;
  logic                 bv_r, bv_nxt;
  logic                 hit_r, hit_nxt;
  logic [TIME_BITS-1:0] tgt_r, tgt_nxt;
  logic [TIME_BITS-1:0] rdata_r;
  logic [CNTW-1:0]      eff;
  logic [CNTW:0]        mid_sum;
  logic                 mem_we;
  logic                 mem_re;
  logic                 res_push;
  logic                 res_full;
  result_t              res_data;
  logic [$bits(result_t)-1:0] res_rd_data;

  // Count register, clamped to the table depth when used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_entry_count;
    end
  end

  assign eff = (32'(count_r) > 32'(TABLE_DEPTH)) ? CNTW'(TABLE_DEPTH) : CNTW'(count_r);

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hx_r   <= hx_nxt;
    mid_r  <= mid_nxt;
    best_r <= best_nxt;
    bv_r   <= bv_nxt;
    hit_r  <= hit_nxt;
    tgt_r  <= tgt_nxt;
  end

  // Next state: the window is [lo, hx) and a probe result arrives each cycle.
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hx_nxt    = hx_r;
    best_nxt  = best_r;
    bv_nxt    = bv_r;
    hit_nxt   = hit_r;
    tgt_nxt   = tgt_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            tgt_nxt   = TIME_BITS'(cmd.time_value);
            lo_nxt    = '0;
            hx_nxt    = eff;
            best_nxt  = '0;
            bv_nxt    = 1'b0;
            hit_nxt   = 1'b0;
            state_nxt = (eff != '0) ? ST_PROBE : ST_REPLY;
          end
        end
      end
      ST_PROBE: begin
        if (rdata_r == tgt_r) begin
          best_nxt = mid_r;
          bv_nxt   = 1'b1;
          hit_nxt  = 1'b1;
        end else if (rdata_r < tgt_r) begin
          best_nxt = mid_r;
          bv_nxt   = 1'b1;
          lo_nxt   = CNTW'(mid_r) + 1'b1;
        end else begin
          hx_nxt = CNTW'(mid_r);
        end
        if (hit_nxt || (lo_nxt >= hx_nxt)) begin
          state_nxt = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Midpoint of the next window, floor((low + high) / 2) with high = hx - 1.
  always_comb begin
    mid_sum = {1'b0, lo_nxt} + {1'b0, hx_nxt} - 1'b1;
    mid_nxt = mid_sum[AW:1];
    mem_re  = (state_nxt == ST_PROBE);
  end

  // Table write and registered probe read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd.index)] <= TIME_BITS'(cmd.time_value);
    end
    if (mem_re) begin
      rdata_r <= mem[mid_nxt];
    end
  end

  // Answer beat.
  always_comb begin
    res_data.found        = bv_r;
    res_data.exact_hit    = hit_r;
    res_data.result_index = bv_r ? INDEX_W'(best_r) : '0;
  end

  stfs_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd_data),
    .empty   (out_empty)
  );

  assign out_res = result_t'(res_rd_data);

endmodule
